>>> rtl/bdlc_pkg.sv
package bdlc_pkg;

  localparam int NumButtons = 9;
  localparam int IdxW       = 4;
  localparam int TimeW      = 32;
  localparam int PeriodW    = 16;
  localparam int CfgIdxW    = 8;
  localparam int CfgDataW   = 16;

  localparam logic [PeriodW-1:0]    DebounceReset  = 16'd8;
  localparam logic [PeriodW-1:0]    CycleReset     = 16'd600;
  localparam logic [PeriodW-1:0]    HeartbeatReset = 16'd250;
  localparam logic [NumButtons-1:0] LedMaskReset   = '0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE  = 8'd0,
    CFG_CYCLE     = 8'd1,
    CFG_HEARTBEAT = 8'd2,
    CFG_LED_MASK  = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0]      now_ms;
    logic [NumButtons-1:0] raw_levels;
  } in_t;

  typedef struct packed {
    logic [NumButtons-1:0] pressed_mask;
    logic                  lit_valid;
    logic [IdxW-1:0]       lit_index;
    logic [NumButtons-1:0] led_drive;
    logic                  report_strobe;
    logic [TimeW-1:0]      up_time;
  } out_t;

  typedef struct packed {
    logic [PeriodW-1:0]    debounce_time;
    logic [PeriodW-1:0]    cycle_period;
    logic [PeriodW-1:0]    heartbeat_gap;
    logic [NumButtons-1:0] led_present_mask;
  } cfg_t;

  typedef struct packed {
    logic            active;
    logic [IdxW-1:0] pos;
  } lit_t;

  // Round-robin search for the next button with an LED after the lit one.
  function automatic lit_t lit_advance(lit_t cur, logic [NumButtons-1:0] mask);
    lit_t          res;
    logic [IdxW:0] base;
    logic [IdxW:0] idx;
    res.active = 1'b0;
    res.pos    = '0;
    base = cur.active ? {1'b0, cur.pos} : (IdxW+1)'(NumButtons - 1);
    // walk from the farthest step back so the nearest hit wins
    for (int s = NumButtons; s >= 1; s--) begin
      idx = base + (IdxW+1)'(s);
      if (idx >= (IdxW+1)'(NumButtons)) begin
        idx = idx - (IdxW+1)'(NumButtons);
      end
      if (mask[idx[IdxW-1:0]]) begin
        res.active = 1'b1;
        res.pos    = idx[IdxW-1:0];
      end
    end
    return res;
  endfunction

endpackage

>>> rtl/bdlc_cfg_regs.sv
module bdlc_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bdlc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bdlc_pkg::CfgDataW-1:0] cfg_data_i,
  output bdlc_pkg::cfg_t           cfg_o
);
  import bdlc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE:  cfg_d.debounce_time    = cfg_data_i;
        CFG_CYCLE:     cfg_d.cycle_period     = cfg_data_i;
        CFG_HEARTBEAT: cfg_d.heartbeat_gap    = cfg_data_i;
        CFG_LED_MASK:  cfg_d.led_present_mask = cfg_data_i[NumButtons-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time    <= DebounceReset;
      cfg_q.cycle_period     <= CycleReset;
      cfg_q.heartbeat_gap    <= HeartbeatReset;
      cfg_q.led_present_mask <= LedMaskReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/bdlc_scan.sv
module bdlc_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  bdlc_pkg::in_t  scan_i,
  input  bdlc_pkg::cfg_t cfg_i,
  output bdlc_pkg::out_t res_o
);
  import bdlc_pkg::*;

  logic [NumButtons-1:0] last_q, last_d;
  logic [NumButtons-1:0] deb_q, deb_d;
  logic [TimeW-1:0]      ct_q [NumButtons];
  logic [TimeW-1:0]      ct_d [NumButtons];
  logic [TimeW-1:0]      cyc_q, cyc_d;
  logic [TimeW-1:0]      rep_q, rep_d;
  lit_t                  lit_q, lit_d;
  logic                  started_q;

  logic [TimeW-1:0]      now;
  logic [NumButtons-1:0] pressed;
  logic [NumButtons-1:0] settled;
  lit_t                  lit0;
  logic                  cyc_hit;
  logic                  lit_chg;
  logic                  dirty;
  logic                  strobe;

  assign now     = scan_i.now_ms;
  assign pressed = ~scan_i.raw_levels;

  // first scan makes the initial advance from nothing lit
  assign lit0 = started_q ? lit_q : lit_advance(lit_q, cfg_i.led_present_mask);

  always_comb begin
    for (int i = 0; i < NumButtons; i++) begin
      ct_d[i]    = (pressed[i] != last_q[i]) ? now : ct_q[i];
      settled[i] = (now - ct_d[i]) >= {{(TimeW-PeriodW){1'b0}}, cfg_i.debounce_time};
      deb_d[i]   = settled[i] ? pressed[i] : deb_q[i];
    end
  end

  assign last_d  = pressed;
  assign cyc_hit = (now - cyc_q) >= {{(TimeW-PeriodW){1'b0}}, cfg_i.cycle_period};
  assign cyc_d   = cyc_hit ? now : cyc_q;
  assign lit_d   = cyc_hit ? lit_advance(lit0, cfg_i.led_present_mask) : lit0;
  assign lit_chg = cyc_hit && ((lit0.active != lit_d.active) ||
                               (lit_d.active && (lit0.pos != lit_d.pos)));
  assign dirty   = (deb_d != deb_q) || lit_chg;
  assign strobe  = dirty ||
                   ((now - rep_q) >= {{(TimeW-PeriodW){1'b0}}, cfg_i.heartbeat_gap});
  assign rep_d   = strobe ? now : rep_q;

  always_comb begin
    res_o.pressed_mask  = deb_d;
    res_o.lit_valid     = lit_d.active;
    res_o.lit_index     = lit_d.active ? lit_d.pos : '0;
    res_o.led_drive     = lit_d.active ?
                          ((NumButtons'(1) << lit_d.pos) & cfg_i.led_present_mask) : '0;
    res_o.report_strobe = strobe;
    res_o.up_time       = now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      deb_q     <= '0;
      cyc_q     <= '0;
      rep_q     <= '0;
      lit_q     <= '0;
      started_q <= 1'b0;
      for (int i = 0; i < NumButtons; i++) begin
        ct_q[i] <= '0;
      end
    end else if (fire_i) begin
      last_q    <= last_d;
      deb_q     <= deb_d;
      cyc_q     <= cyc_d;
      rep_q     <= rep_d;
      lit_q     <= lit_d;
      started_q <= 1'b1;
      for (int i = 0; i < NumButtons; i++) begin
        ct_q[i] <= ct_d[i];
      end
    end
  end

endmodule

>>> rtl/button_debounce_led_cycler_core.sv
// Debounces nine active-low buttons and rotates one LED among the buttons
// that have one. Each scan word carries a millisecond timestamp and the raw
// pin levels; each scan yields exactly one result word with the debounced
// mask, the lit LED and a report strobe. One scan is taken per clock cycle
// while the result register is not stalled. The scan is first held in the
// input register, then the per-button timer compares, the round-robin LED
// search and the strobe decision resolve in one pass into the result
// register, which presents the result word. A stalled result word holds
// the scan stage, which then stalls the input.
// Configuration writes are taken every cycle and belong in idle periods.
module button_debounce_led_cycler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bdlc_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bdlc_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bdlc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bdlc_pkg::CfgDataW-1:0] cfg_data_i
);
  import bdlc_pkg::*;

  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q;
  logic fire;
  cfg_t cfg;
  out_t res;

  // advance the scan stage when the result register is free or draining
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  bdlc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bdlc_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .scan_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
